/* rtl/core/hmwf_pkg.sv */
// Shared types and constants for the 3x3 hit-or-miss window filter.
package hmwf_pkg;

  localparam int KROWS   = 3;
  localparam int KCOLS   = 3;
  localparam int KSIZE   = KROWS * KCOLS;
  localparam int SIZE_W  = 11;
  localparam int POS_W   = 10;
  localparam int VALUE_W = 9;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;
  localparam int MIN_SIZE     = 3;
  localparam int HEIGHT_LIMIT = 1024;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CARE   = 3'd2;
  localparam logic [2:0] REG_VALUE  = 3'd3;
  localparam logic [2:0] REG_THIN   = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
    logic [KSIZE-1:0]  care_mask;
    logic [KSIZE-1:0]  value_mask;
    logic              thin_mode;
  } cfg_t;

endpackage

/* rtl/core/hmwf_ram.sv */
// Generic simple dual-port RAM with registered read.
module hmwf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/hmwf_regs.sv */
// APB configuration registers of the window filter.
module hmwf_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hmwf_pkg::PADDR_W-1:0]   paddr,
  input  logic [hmwf_pkg::DATA_W-1:0]    pwdata,
  output logic [hmwf_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output hmwf_pkg::cfg_t                 cfg
);

  hmwf_pkg::cfg_t cfg_r;
  hmwf_pkg::cfg_t cfg_nxt;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[hmwf_pkg::PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        hmwf_pkg::REG_WIDTH:  cfg_nxt.image_width  = pwdata[hmwf_pkg::SIZE_W-1:0];
        hmwf_pkg::REG_HEIGHT: cfg_nxt.image_height = pwdata[hmwf_pkg::SIZE_W-1:0];
        hmwf_pkg::REG_CARE:   cfg_nxt.care_mask    = pwdata[hmwf_pkg::KSIZE-1:0];
        hmwf_pkg::REG_VALUE:  cfg_nxt.value_mask   = pwdata[hmwf_pkg::KSIZE-1:0];
        hmwf_pkg::REG_THIN:   cfg_nxt.thin_mode    = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= hmwf_pkg::SIZE_W'(1024);
      cfg_r.image_height <= hmwf_pkg::SIZE_W'(1024);
      cfg_r.care_mask    <= '0;
      cfg_r.value_mask   <= '0;
      cfg_r.thin_mode    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      hmwf_pkg::REG_WIDTH:  prdata = hmwf_pkg::DATA_W'(cfg_r.image_width);
      hmwf_pkg::REG_HEIGHT: prdata = hmwf_pkg::DATA_W'(cfg_r.image_height);
      hmwf_pkg::REG_CARE:   prdata = hmwf_pkg::DATA_W'(cfg_r.care_mask);
      hmwf_pkg::REG_VALUE:  prdata = hmwf_pkg::DATA_W'(cfg_r.value_mask);
      hmwf_pkg::REG_THIN:   prdata = hmwf_pkg::DATA_W'(cfg_r.thin_mode);
      default:              prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/hmwf_cell.sv */
// One window column cell: holds a kernel column and checks it against the masks.
module hmwf_cell #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        en,
  input  logic [hmwf_pkg::KROWS-1:0][PIXEL_BITS-1:0]  col_in,
  input  logic [hmwf_pkg::KROWS-1:0]                  care,
  input  logic [hmwf_pkg::KROWS-1:0]                  want,
  output logic [hmwf_pkg::KROWS-1:0][PIXEL_BITS-1:0]  col_out,
  output logic                                        match
);

  logic [hmwf_pkg::KROWS-1:0][PIXEL_BITS-1:0] col_r;

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < hmwf_pkg::KROWS; i++) begin
      if (care[i] && (col_r[i] != PIXEL_BITS'(want[i]))) begin
        match = 1'b0;
      end
    end
  end

  assign col_out = col_r;

endmodule

/* rtl/core/hit_or_miss_window_filter_top.sv */
// Top level of the 3x3 hit-or-miss / thinning window filter.
//
// Pixels enter in raster order on the in_ channel (in_valid, in_stall,
// in_pixel), one beat per pixel. For every interior centre one result beat
// leaves on the out_ channel: centre row and column, the hit flag (or the
// centre minus the hit in thinning mode) and out_last on the final interior
// centre. Border pixels give no beat.
// Throughput: one pixel per cycle while the receiver does not stall, set by the line
// memory (one read and one write per cycle) and the chain of three column cells that shifts per pixel.
// A result passes stage A (line memory read), stage B (window shift into the column
// cells) and the output register before it is valid on out_.
// When the receiver stalls, the pending beat holds; bubbles upstream still
// close up, and in_stall rises once every stage is full.
// Reset clears the pipeline, the row/column counters and the registers
// (width 1024, height 1024, masks 0, hit-or-miss mode). Line memory needs no
// clearing: every entry is written in a row before it is read.
// Configuration over APB: width, height, care mask, value mask, thin mode at
// byte addresses 0, 4, 8, 12, 16.
module hit_or_miss_window_filter_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [PIXEL_BITS-1:0]                 in_pixel,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [hmwf_pkg::POS_W-1:0]            out_row,
  output logic [hmwf_pkg::POS_W-1:0]            out_col,
  output logic signed [hmwf_pkg::VALUE_W-1:0]   out_value,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [hmwf_pkg::PADDR_W-1:0]          paddr,
  input  logic [hmwf_pkg::DATA_W-1:0]           pwdata,
  output logic [hmwf_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int LINE_W = (hmwf_pkg::KROWS - 1) * PIXEL_BITS;
  localparam int DIFF_W = (PIXEL_BITS > hmwf_pkg::VALUE_W ? PIXEL_BITS : hmwf_pkg::VALUE_W) + 1;
  localparam int SW     = hmwf_pkg::SIZE_W;
  localparam int PW     = hmwf_pkg::POS_W;

  hmwf_pkg::cfg_t cfg;

  hmwf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // clamped sizes
  logic [SW-1:0] w_lim;
  logic [SW-1:0] h_lim;

  always_comb begin
    if (cfg.image_width < SW'(hmwf_pkg::MIN_SIZE)) begin
      w_lim = SW'(hmwf_pkg::MIN_SIZE);
    end else if (int'(cfg.image_width) > MAX_WIDTH) begin
      w_lim = SW'(MAX_WIDTH);
    end else begin
      w_lim = cfg.image_width;
    end
    if (cfg.image_height < SW'(hmwf_pkg::MIN_SIZE)) begin
      h_lim = SW'(hmwf_pkg::MIN_SIZE);
    end else if (int'(cfg.image_height) > hmwf_pkg::HEIGHT_LIMIT) begin
      h_lim = SW'(hmwf_pkg::HEIGHT_LIMIT);
    end else begin
      h_lim = cfg.image_height;
    end
  end

  // pipeline handshake
  logic a_valid_r, b_valid_r, out_valid_r;
  logic b_emit_r;
  logic out_ready, b_ready, a_ready;
  logic in_acc, a_move, b_move, out_load;

  assign out_ready = !out_valid_r || !out_stall;
  assign b_ready   = !b_valid_r || !b_emit_r || out_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_stall  = !a_ready;
  assign in_acc    = in_valid && a_ready;
  assign a_move    = a_valid_r && b_ready;
  assign b_move    = b_valid_r && b_emit_r && out_ready;
  assign out_load  = b_move;

  // raster counters
  logic [PW-1:0] col_r, col_nxt;
  logic [PW-1:0] row_r, row_nxt;
  logic [SW-1:0] col_inc, row_inc;
  logic [AW-1:0] slot;

  assign col_inc = SW'(col_r) + SW'(1);
  assign row_inc = SW'(row_r) + SW'(1);
  assign slot    = (int'(col_r) >= MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : AW'(col_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_inc >= w_lim) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_lim) ? '0 : PW'(row_inc);
      end else begin
        col_nxt = PW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage A: pixel waits for its line memory column
  logic [PIXEL_BITS-1:0] a_px_r;
  logic [AW-1:0]         a_slot_r;
  logic                  a_emit_r;
  logic [PW-1:0]         a_row_r, a_col_r;
  logic                  a_last_r;
  logic [LINE_W-1:0]     line_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_px_r   <= in_pixel;
      a_slot_r <= slot;
      a_emit_r <= (row_r >= PW'(2)) && (col_r >= PW'(2));
      a_row_r  <= row_r - PW'(1);
      a_col_r  <= col_r - PW'(1);
      a_last_r <= (SW'(row_r) == h_lim - SW'(1)) && (SW'(col_r) == w_lim - SW'(1));
    end
  end

  // line memory word: low half newest row, high half older row
  hmwf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (a_move),
    .waddr (a_slot_r),
    .wdata ({line_rd[PIXEL_BITS-1:0], a_px_r}),
    .re    (in_acc),
    .raddr (slot),
    .rdata (line_rd)
  );

  // stage B: window column cells
  logic [hmwf_pkg::KCOLS:0][hmwf_pkg::KROWS-1:0][PIXEL_BITS-1:0] chain;
  logic [hmwf_pkg::KCOLS-1:0] col_match;
  logic [PW-1:0] b_row_r, b_col_r;
  logic          b_last_r;

  assign chain[hmwf_pkg::KCOLS] = {a_px_r, line_rd[PIXEL_BITS-1:0],
                                   line_rd[LINE_W-1:PIXEL_BITS]};

  for (genvar j = 0; j < hmwf_pkg::KCOLS; j++) begin : g_cell
    hmwf_cell #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_cell (
      .clk     (clk),
      .en      (a_move),
      .col_in  (chain[j+1]),
      .care    ({cfg.care_mask[2*hmwf_pkg::KCOLS+j], cfg.care_mask[hmwf_pkg::KCOLS+j],
                 cfg.care_mask[j]}),
      .want    ({cfg.value_mask[2*hmwf_pkg::KCOLS+j], cfg.value_mask[hmwf_pkg::KCOLS+j],
                 cfg.value_mask[j]}),
      .col_out (chain[j]),
      .match   (col_match[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_emit_r <= a_emit_r;
      b_row_r  <= a_row_r;
      b_col_r  <= a_col_r;
      b_last_r <= a_last_r;
    end
  end

  logic              hit;
  logic [DIFF_W-1:0] diff;

  assign hit  = &col_match;
  assign diff = DIFF_W'(chain[1][1]) - DIFF_W'(hit);

  // output register
  logic [PW-1:0]                  out_row_r, out_col_r;
  logic [hmwf_pkg::VALUE_W-1:0]   out_value_r;
  logic                           out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= b_move;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r   <= b_row_r;
      out_col_r   <= b_col_r;
      out_value_r <= cfg.thin_mode ? diff[hmwf_pkg::VALUE_W-1:0]
                                   : hmwf_pkg::VALUE_W'(hit);
      out_last_r  <= b_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !a_valid_r && !b_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> a_valid_r)
    else $error("accepted pixel lost at stage A");

  a_b_holds: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_emit_r && !out_ready |=> b_valid_r && b_emit_r)
    else $error("stage B dropped a result while output blocked");

  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_r != '0) && (out_col_r != '0))
    else $error("result emitted for border centre");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the 3x3 hit-or-miss window filter: directed and random pixel streams.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [hmwf_pkg::POS_W-1:0]          row;
    logic [hmwf_pkg::POS_W-1:0]          col;
    logic signed [hmwf_pkg::VALUE_W-1:0] value;
    logic                                is_last;
  } centre_t;

  typedef struct {
    logic [hmwf_pkg::SIZE_W-1:0]         width;
    logic [hmwf_pkg::SIZE_W-1:0]         height;
    logic [hmwf_pkg::KSIZE-1:0]          care;
    logic [hmwf_pkg::KSIZE-1:0]          val;
    logic                                thin;
    logic [7:0]                          pix [hmwf_pkg::KSIZE];
    logic signed [hmwf_pkg::VALUE_W-1:0] want;
  } probe_t;

  typedef enum {PIX_BINARY, PIX_FLAT, PIX_NOISE} texture_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [hmwf_pkg::POS_W-1:0] out_row;
  logic [hmwf_pkg::POS_W-1:0] out_col;
  logic signed [hmwf_pkg::VALUE_W-1:0] out_value;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [hmwf_pkg::PADDR_W-1:0] paddr = '0;
  logic [hmwf_pkg::DATA_W-1:0] pwdata = '0;
  logic [hmwf_pkg::DATA_W-1:0] prdata;
  logic pready;

  hit_or_miss_window_filter_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // window model state
  logic [hmwf_pkg::SIZE_W-1:0] cur_width = 11'd1024;
  logic [hmwf_pkg::SIZE_W-1:0] cur_height = 11'd1024;
  logic [hmwf_pkg::KSIZE-1:0]  cur_care = '0;
  logic [hmwf_pkg::KSIZE-1:0]  cur_value = '0;
  logic                        cur_thin = 1'b0;
  logic [7:0]                  line_new [1024] = '{default: 8'd0};
  logic [7:0]                  line_old [1024] = '{default: 8'd0};
  logic [7:0]                  win [hmwf_pkg::KROWS][hmwf_pkg::KCOLS] =
                                 '{default: '{default: 8'd0}};
  logic [hmwf_pkg::POS_W-1:0]  row_pos = '0;
  logic [hmwf_pkg::POS_W-1:0]  col_pos = '0;

  centre_t centre_q [$];
  int mismatches = 0;
  int burst_left = 0;

  probe_t probes [3] = '{
    '{11'd0, 11'd1, 9'h1FF, 9'h1FF, 1'b0,
      '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1}, 9'sd1},
    '{11'd2, 11'd0, 9'h1FF, 9'h000, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, -9'sd1},
    '{11'd3, 11'd3, 9'h010, 9'h010, 1'b1,
      '{8'd1, 8'd0, 8'd1, 8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd1}, 9'sd255}
  };

  function automatic int clamp_size(logic [hmwf_pkg::SIZE_W-1:0] v);
    if (v < hmwf_pkg::MIN_SIZE) return hmwf_pkg::MIN_SIZE;
    if (v > hmwf_pkg::HEIGHT_LIMIT) return hmwf_pkg::HEIGHT_LIMIT;
    return int'(v);
  endfunction

  function automatic logic [7:0] next_pixel(texture_t tex, bit base);
    case (tex)
      PIX_FLAT: begin
        if ($urandom_range(0, 9) == 0) return {7'd0, ~base};
        if ($urandom_range(0, 29) == 0) return 8'($urandom_range(2, 255));
        return {7'd0, base};
      end
      PIX_NOISE: return 8'($urandom_range(0, 255));
      default: begin
        if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 1));
      end
    endcase
  endfunction

  // shift one pixel into the window and work out the centre it completes, if any
  task automatic filter_pixel(input logic [7:0] px, output bit got, output centre_t res);
    int w;
    int h;
    int r;
    int c;
    bit hit;
    w = clamp_size(cur_width);
    h = clamp_size(cur_height);
    r = int'(row_pos);
    c = int'(col_pos);
    for (int i = 0; i < hmwf_pkg::KROWS; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_old[c];
    win[1][2] = line_new[c];
    win[2][2] = px;
    line_old[c] = line_new[c];
    line_new[c] = px;
    got = (r >= 2 && c >= 2);
    hit = 1'b1;
    for (int k = 0; k < hmwf_pkg::KSIZE; k++) begin
      if (cur_care[k] && win[k / hmwf_pkg::KCOLS][k % hmwf_pkg::KCOLS] != {7'd0, cur_value[k]})
        hit = 1'b0;
    end
    res.row = hmwf_pkg::POS_W'(r - 1);
    res.col = hmwf_pkg::POS_W'(c - 1);
    res.value = cur_thin ?
                hmwf_pkg::VALUE_W'({1'b0, win[1][1]} - hmwf_pkg::VALUE_W'(hit)) :
                hmwf_pkg::VALUE_W'(hit);
    res.is_last = (r == h - 1 && c == w - 1);
    if (c + 1 >= w) begin
      col_pos = '0;
      row_pos = (r + 1 >= h) ? '0 : hmwf_pkg::POS_W'(r + 1);
    end else begin
      col_pos = hmwf_pkg::POS_W'(c + 1);
    end
  endtask

  task automatic feed_pixel(input logic [7:0] px, output bit got, output centre_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_pixel(px, got, res);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (centre_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [hmwf_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      hmwf_pkg::REG_WIDTH:  cur_width = data[hmwf_pkg::SIZE_W-1:0];
      hmwf_pkg::REG_HEIGHT: cur_height = data[hmwf_pkg::SIZE_W-1:0];
      hmwf_pkg::REG_CARE:   cur_care = data[hmwf_pkg::KSIZE-1:0];
      hmwf_pkg::REG_VALUE:  cur_value = data[hmwf_pkg::KSIZE-1:0];
      hmwf_pkg::REG_THIN:   cur_thin = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [4:0] sel,
                                input logic [hmwf_pkg::SIZE_W-1:0] w,
                                input logic [hmwf_pkg::SIZE_W-1:0] h,
                                input logic [hmwf_pkg::KSIZE-1:0] care,
                                input logic [hmwf_pkg::KSIZE-1:0] val, input logic thin);
    if (sel[hmwf_pkg::REG_WIDTH])
      cfg_write(hmwf_pkg::REG_WIDTH, hmwf_pkg::DATA_W'(w));
    if (sel[hmwf_pkg::REG_HEIGHT])
      cfg_write(hmwf_pkg::REG_HEIGHT, hmwf_pkg::DATA_W'(h));
    if (sel[hmwf_pkg::REG_CARE])
      cfg_write(hmwf_pkg::REG_CARE, hmwf_pkg::DATA_W'(care));
    if (sel[hmwf_pkg::REG_VALUE])
      cfg_write(hmwf_pkg::REG_VALUE, hmwf_pkg::DATA_W'(val));
    if (sel[hmwf_pkg::REG_THIN])
      cfg_write(hmwf_pkg::REG_THIN, hmwf_pkg::DATA_W'(thin));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [hmwf_pkg::KSIZE-1:0] pick_care();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return hmwf_pkg::KSIZE'($urandom);
      default: return hmwf_pkg::KSIZE'($urandom & $urandom & $urandom);
    endcase
  endfunction

  function automatic logic [hmwf_pkg::KSIZE-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return hmwf_pkg::KSIZE'($urandom);
    endcase
  endfunction

  // receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int stall_span = 0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(16, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    centre_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (centre_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: row %0d col %0d value %0d last %0b",
                   out_row, out_col, out_value, out_last);
      end else begin
        want = centre_q.pop_front();
        if (out_row !== want.row || out_col !== want.col || out_value !== want.value ||
            out_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result beat: expected row %0d col %0d value %0d last %0b",
                     want.row, want.col, want.value, want.is_last);
            $display("             got      row %0d col %0d value %0d last %0b",
                     out_row, out_col, out_value, out_last);
          end
        end
      end
    end
  end

  initial begin
    bit got;
    centre_t res;
    int fed;
    int img;
    int mid_at;
    int n_in_img;
    bit base;
    texture_t tex;
    logic [hmwf_pkg::SIZE_W-1:0] w_raw;
    logic [hmwf_pkg::SIZE_W-1:0] h_raw;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one 3x3 image per probe; each gives a single centre whose value is known
    foreach (probes[i]) begin
      settle();
      apply_settings(5'h1F, probes[i].width, probes[i].height, probes[i].care,
                     probes[i].val, probes[i].thin);
      for (int k = 0; k < hmwf_pkg::KSIZE; k++) begin
        feed_pixel(probes[i].pix[k], got, res);
        if (got) begin
          res.row = 10'd1;
          res.col = 10'd1;
          res.value = probes[i].want;
          res.is_last = 1'b1;
          centre_q.push_back(res);
        end
      end
    end

    fed = 0;
    img = 0;
    while (fed < 2000) begin
      settle();
      w_raw = hmwf_pkg::SIZE_W'($urandom_range(0, 14));
      h_raw = hmwf_pkg::SIZE_W'($urandom_range(0, 10));
      apply_settings((img == 0) ? 5'h1F : (5'($urandom) | 5'b00011), w_raw, h_raw,
                     pick_care(), pick_value(), 1'($urandom));
      tex = ($urandom_range(0, 3) == 3) ? PIX_NOISE :
            ($urandom_range(0, 1) ? PIX_FLAT : PIX_BINARY);
      base = 1'($urandom);
      mid_at = ($urandom_range(0, 3) == 0) ?
               $urandom_range(1, clamp_size(cur_width) * clamp_size(cur_height) - 1) : -1;
      n_in_img = 0;
      do begin
        if (n_in_img == mid_at) begin
          // mid-image change: width may only shrink, so every line entry read was written
          settle();
          apply_settings(5'($urandom) | 5'b11100,
                         hmwf_pkg::SIZE_W'($urandom_range(0, clamp_size(cur_width))),
                         hmwf_pkg::SIZE_W'($urandom_range(0, 12)), pick_care(),
                         pick_value(), 1'($urandom));
        end
        feed_pixel(next_pixel(tex, base), got, res);
        if (got) centre_q.push_back(res);
        n_in_img++;
        fed++;
      end while (row_pos != 0 || col_pos != 0);
      img++;
    end

    settle();
    if (mismatches == 0 && centre_q.size() == 0)
      $display("hit_or_miss_window_filter_top: match");
    else
      $display("hit_or_miss_window_filter_top: mismatch");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("hit_or_miss_window_filter_top: mismatch");
    $finish;
  end

endmodule

/* files.f */
rtl/core/hmwf_pkg.sv
rtl/core/hmwf_ram.sv
rtl/core/hmwf_regs.sv
rtl/core/hmwf_cell.sv
rtl/core/hit_or_miss_window_filter_top.sv
tb/sv/tb_top.sv
